[rtl/sroc_pkg.sv]
// shared types, codes and keyword tables for the read-only sql classifier
// no dependencies; imported by every module of the block
package sroc_pkg;

    localparam int KW_COUNT = 8;
    localparam int KW_CHARS = 8;
    localparam int POS_W    = 4;
    localparam logic [POS_W-1:0] POS_SAT = 4'd9;

    // ascii codes used by the byte classifier in the front end
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // keyword letters, unused tail positions are zero
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_CHARS] = '{
        '{"S", "E", "L", "E", "C", "T", 8'h00, 8'h00},
        '{"F", "R", "O", "M", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"W", "I", "T", "H", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"V", "A", "L", "U", "E", "S", 8'h00, 8'h00},
        '{"D", "E", "S", "C", "R", "I", "B", "E"},
        '{"D", "E", "S", "C", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "H", "O", "W", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"E", "X", "P", "L", "A", "I", "N", 8'h00}
    };
    localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd4, 4'd4, 4'd6, 4'd8, 4'd4, 4'd4, 4'd7
    };

    // reject reasons
    localparam logic [1:0] RS_OK      = 2'd0;
    localparam logic [1:0] RS_BLOCK   = 2'd1;
    localparam logic [1:0] RS_CHAIN   = 2'd2;
    localparam logic [1:0] RS_KEYWORD = 2'd3;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_BLOCK,
        PH_LINE,
        PH_STMT
    } t_phase;

    typedef enum logic [1:0] {
        MK_NONE,
        MK_SLASH,
        MK_DASH,
        MK_STAR
    } t_mark;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic       readonly_ok;
        logic [1:0] reject_reason;
    } t_out_item;

    // classified byte as it sits in the queue
    typedef struct packed {
        logic [7:0] upper;
        logic       ws;
        logic       slash;
        logic       dash;
        logic       star;
        logic       nl;
        logic       semi;
        logic       zero;
        logic       is_last;
    } t_cls;

    typedef struct packed {
        logic valid;
        t_cls item;
    } t_q_head;

    typedef struct packed {
        t_phase              phase;
        t_mark               mark;
        logic [KW_COUNT-1:0] alive;
        logic [POS_W-1:0]    pos;
        logic                chain;
        logic                ended;
    } t_scan;

    localparam t_scan SCAN_RESET = '{
        phase: PH_LEAD,
        mark:  MK_NONE,
        alive: {KW_COUNT{1'b1}},
        pos:   '0,
        chain: 1'b0,
        ended: 1'b0
    };

    // one statement byte against every keyword still in the race
    function automatic logic [KW_COUNT-1:0] kw_step(
        input logic [KW_COUNT-1:0] alive,
        input logic [POS_W-1:0]    pos,
        input logic [7:0]          up,
        input logic                ws
    );
        logic [KW_COUNT-1:0] res;
        res = alive;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (pos < KW_LEN[k]) begin
                if (up != KW_TEXT[k][pos[2:0]]) res[k] = 1'b0;
            end else if (pos == KW_LEN[k]) begin
                if (!ws) res[k] = 1'b0;
            end
        end
        return res;
    endfunction

endpackage

[rtl/sql_readonly_classifier_unit.sv]
// top level: read-only sql classifier, one statement byte per item
// a last-marked item's result is registered as the scanner takes it from the queue
// throughput: one byte per cycle, but a last-marked byte waits while a result is unread
// a two-item queue parts the classifying front end from the scanner, an output
// register parts the scanner from the consumer; synchronous active-low reset
// returns the scanner to leading skip and empties queue and output register
module sql_readonly_classifier_unit
    import sroc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_q_head w_head;
    logic    w_pop;

    sroc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_pop      (w_pop),
        .o_head     (w_head)
    );

    sroc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // verdict flag agrees with the reason code
    a_ok_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.readonly_ok == (o_out_item.reject_reason == RS_OK)))
        else $error("readonly_ok disagrees with reject_reason");

    // a full queue always presents an item to the scanner
    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> w_head.valid)
        else $error("queue full without a head item");

    // a result appears only after a last-marked item left the queue
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_pop && w_head.item.is_last))
        else $error("result without a last-marked item");

    // the scanner never takes an item from an empty queue
    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from empty queue");

endmodule

[rtl/sroc_front.sv]
// front end: accepts input items, classifies each byte, two-entry queue
// depends on sroc_pkg
module sroc_front
    import sroc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_pop,
    output t_q_head  o_head
);

    t_cls       r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       w_push;
    t_cls       w_cls;
    logic [7:0] w_c;

    assign o_in_ready = (r_count != 2'd2);
    assign w_push     = i_in_valid && o_in_ready;
    assign w_c        = i_in_item.char_byte;

    // byte classification
    always_comb begin
        w_cls.upper   = (w_c >= CH_LOW_A && w_c <= CH_LOW_Z) ? w_c - CASE_GAP : w_c;
        w_cls.ws      = (w_c == CH_SPACE) || (w_c >= CH_TAB && w_c <= CH_CR);
        w_cls.slash   = (w_c == CH_SLASH);
        w_cls.dash    = (w_c == CH_DASH);
        w_cls.star    = (w_c == CH_STAR);
        w_cls.nl      = (w_c == CH_NL);
        w_cls.semi    = (w_c == CH_SEMI);
        w_cls.zero    = (w_c == 8'h00);
        w_cls.is_last = i_in_item.is_last;
    end

    // queue occupancy
    always_comb begin
        n_count = r_count;
        if (w_push && !i_pop) n_count = r_count + 2'd1;
        else if (!w_push && i_pop) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop) r_rd_ptr <= ~r_rd_ptr;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_buf[r_wr_ptr] <= w_cls;
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_buf[r_rd_ptr];

endmodule

[rtl/sroc_back.sv]
// back end: scanner state machine, keyword match, verdict and output register
// depends on sroc_pkg
module sroc_back
    import sroc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_scan      r_scan;
    t_scan      n_scan;
    t_scan      w_after;
    logic       r_out_valid;
    t_out_item  r_out_item;
    logic [1:0] w_reason;
    logic       w_hit;
    t_cls       w_c;

    assign w_c   = i_head.item;
    assign o_pop = i_head.valid && (!w_c.is_last || !r_out_valid || i_out_ready);

    // scanner next state for the item at the queue head
    always_comb begin
        w_after = r_scan;
        if (!r_scan.ended) begin
            if (w_c.zero) begin
                w_after.ended = 1'b1;
            end else begin
                unique case (r_scan.phase)
                    PH_LEAD: begin
                        w_after.mark = MK_NONE;
                        if (r_scan.mark == MK_SLASH || r_scan.mark == MK_DASH) begin
                            if (r_scan.mark == MK_SLASH && w_c.star) begin
                                w_after.phase = PH_BLOCK;
                            end else if (r_scan.mark == MK_DASH && w_c.dash) begin
                                w_after.phase = PH_LINE;
                            end else begin
                                // held mark starts the statement, no keyword survives it
                                w_after.phase = PH_STMT;
                                w_after.alive = '0;
                                w_after.pos   = 4'd2;
                                w_after.chain = w_c.semi;
                            end
                        end else if (w_c.ws) begin
                            w_after.mark = MK_NONE;
                        end else if (w_c.slash) begin
                            w_after.mark = MK_SLASH;
                        end else if (w_c.dash) begin
                            w_after.mark = MK_DASH;
                        end else begin
                            w_after.phase = PH_STMT;
                            w_after.chain = r_scan.chain | w_c.semi;
                            w_after.alive = kw_step(r_scan.alive, r_scan.pos,
                                                    w_c.upper, w_c.ws);
                            w_after.pos   = r_scan.pos + 4'd1;
                        end
                    end
                    PH_BLOCK: begin
                        if (r_scan.mark == MK_STAR && w_c.slash) begin
                            w_after.phase = PH_LEAD;
                            w_after.mark  = MK_NONE;
                        end else begin
                            w_after.mark = w_c.star ? MK_STAR : MK_NONE;
                        end
                    end
                    PH_LINE: begin
                        if (w_c.nl) w_after.phase = PH_LEAD;
                    end
                    PH_STMT: begin
                        w_after.chain = r_scan.chain | w_c.semi;
                        w_after.alive = kw_step(r_scan.alive, r_scan.pos,
                                                w_c.upper, w_c.ws);
                        if (r_scan.pos < POS_SAT) w_after.pos = r_scan.pos + 4'd1;
                    end
                    default: w_after = r_scan;
                endcase
            end
        end
    end

    always_comb begin
        n_scan = r_scan;
        if (o_pop) n_scan = w_c.is_last ? SCAN_RESET : w_after;
    end

    // verdict on the state left by the last item
    always_comb begin
        w_hit = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (w_after.alive[k] && w_after.pos >= KW_LEN[k]) w_hit = 1'b1;
        end
        unique case (w_after.phase)
            PH_BLOCK: w_reason = RS_BLOCK;
            PH_LEAD:  w_reason = RS_KEYWORD;
            PH_LINE:  w_reason = RS_KEYWORD;
            PH_STMT:  w_reason = w_after.chain ? RS_CHAIN : (w_hit ? RS_OK : RS_KEYWORD);
            default:  w_reason = RS_KEYWORD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= SCAN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_scan <= n_scan;
            if (o_pop && w_c.is_last) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (o_pop && w_c.is_last) begin
            r_out_item.readonly_ok   <= (w_reason == RS_OK);
            r_out_item.reject_reason <= w_reason;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
